// File: rtl/vga_timing_capture_macros.svh
// Assertion macros used by the vtc_checker module.
`ifndef VGA_TIMING_CAPTURE_MACROS_SVH
`define VGA_TIMING_CAPTURE_MACROS_SVH

// Check a condition on every clock edge outside reset.
`define VTC_ASSERT_ALWAYS(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("vga_timing_capture check failed");

// Check that a trigger is followed by a condition on the next edge.
`define VTC_ASSERT_NEXT(label, trig, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error("vga_timing_capture check failed");

`endif

// File: rtl/vtc_pkg.sv
// Shared types and constants for the video timing capture block.
package vtc_pkg;

    localparam int CLOCK_DIVIDE = 8;
    localparam int COLOR_BITS   = 8;
    localparam logic [7:0] COLOR_MASK = 8'(((1 << COLOR_BITS) - 1) & 8'hFF);

    localparam int IN_W    = 32;
    localparam int OUT_W   = 24;
    localparam int USER_W  = 3;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 11;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] REG_H_BACK_PORCH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_H_VISIBLE    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_V_VISIBLE    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_V_BACK_PORCH = 2'd3;

    localparam logic [7:0]  H_BACK_PORCH_RST = 8'd48;
    localparam logic [10:0] H_VISIBLE_RST    = 11'd640;
    localparam logic [8:0]  V_VISIBLE_RST    = 9'd480;
    localparam logic [5:0]  V_BACK_PORCH_RST = 6'd33;

    typedef enum logic [2:0] {
        ST_INIT    = 3'd0,
        ST_HBP     = 3'd1,
        ST_DISPLAY = 3'd2,
        ST_WAIT_H  = 3'd3,
        ST_WAIT_V  = 3'd4,
        ST_VBP     = 3'd5
    } capture_state_t;

    typedef struct packed {
        logic [7:0]  h_back_porch;
        logic [10:0] h_visible;
        logic [8:0]  v_visible;
        logic [5:0]  v_back_porch;
    } timing_cfg_t;

    typedef struct packed {
        logic [2:0] tick_phase;
        logic       hsync_level;
        logic       vsync_level;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } sample_t;

    typedef struct packed {
        logic       pixel_valid;
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       line_start;
        logic       frame_start;
    } result_t;

endpackage

// File: rtl/vtc_core.sv
// Capture state machine: state, counters, sync edge history and per-sample result.
module vtc_core
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  vtc_pkg::sample_t     sample,
    input  vtc_pkg::timing_cfg_t cfg,
    output vtc_pkg::result_t     result
);
    import vtc_pkg::*;

    capture_state_t state_reg, state_next;
    logic [10:0] dot_reg, dot_next;
    logic [8:0]  line_reg, line_next;
    logic [5:0]  vbl_reg, vbl_next;
    logic        last_hs_reg, last_vs_reg;

    logic        dot_tick;
    logic        h_rise;
    logic        v_rise;
    logic [10:0] dot_inc;
    logic [5:0]  vbl_inc;

    assign dot_tick = (int'(sample.tick_phase) == CLOCK_DIVIDE - 1);
    assign h_rise   = !last_hs_reg && sample.hsync_level;
    assign v_rise   = !last_vs_reg && sample.vsync_level;
    assign dot_inc  = dot_reg + 11'd1;
    assign vbl_inc  = vbl_reg + 6'd1;

    always_comb
    begin
        state_next = state_reg;
        dot_next   = dot_reg;
        line_next  = line_reg;
        vbl_next   = vbl_reg;
        result     = '0;
        if (dot_tick)
        begin
            dot_next = dot_inc;
            case (state_reg)
                ST_INIT, ST_WAIT_H:
                begin
                    if (h_rise)
                    begin
                        state_next = ST_HBP;
                        dot_next   = '0;
                    end
                end
                ST_HBP:
                begin
                    if (dot_inc >= {3'd0, cfg.h_back_porch})
                    begin
                        state_next        = ST_DISPLAY;
                        dot_next          = '0;
                        line_next         = line_reg + 9'd1;
                        result.line_start = 1'b1;
                    end
                end
                ST_DISPLAY:
                begin
                    result.pixel_valid = 1'b1;
                    result.red_out     = sample.red_in & COLOR_MASK;
                    result.green_out   = sample.green_in & COLOR_MASK;
                    result.blue_out    = sample.blue_in & COLOR_MASK;
                    if (dot_inc >= cfg.h_visible)
                    begin
                        if (line_reg < cfg.v_visible)
                        begin
                            state_next = ST_WAIT_H;
                            dot_next   = '0;
                        end
                        else
                        begin
                            state_next = ST_WAIT_V;
                        end
                    end
                end
                ST_WAIT_V:
                begin
                    if (v_rise)
                    begin
                        state_next = ST_VBP;
                        dot_next   = '0;
                        vbl_next   = '0;
                    end
                end
                ST_VBP:
                begin
                    if (h_rise)
                    begin
                        vbl_next = vbl_inc;
                        if (vbl_inc >= cfg.v_back_porch)
                        begin
                            // next dot tick wraps the counter to zero in back porch
                            result.frame_start = 1'b1;
                            state_next         = ST_HBP;
                            dot_next           = '1;
                            line_next          = '0;
                        end
                    end
                end
                default:
                begin
                    state_next = ST_INIT;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_INIT;
            dot_reg     <= '0;
            line_reg    <= '0;
            vbl_reg     <= '0;
            last_hs_reg <= 1'b0;
            last_vs_reg <= 1'b0;
        end
        else if (step)
        begin
            state_reg   <= state_next;
            dot_reg     <= dot_next;
            line_reg    <= line_next;
            vbl_reg     <= vbl_next;
            last_hs_reg <= sample.hsync_level;
            last_vs_reg <= sample.vsync_level;
        end
    end

endmodule

// File: rtl/vga_timing_capture.sv
// Top level of the video timing capture block: stream ports, config registers, pipeline.
//
// Usage
//   s_axis carries one core-clock sample of the video pins per transfer:
//   tick phase, hsync and vsync levels and the three color levels.
//   m_axis returns exactly one result per sample: tdata holds the captured
//   color (zero unless a pixel was taken), tuser holds the flags.
//   cfg writes the four timing registers; cfg_ready is always high.
//   Write only while no sample is in flight.
// Timing
//   The capture logic runs between the input and output registers, so a
//   sample passes the input register and its result the output register
//   on the way to m_axis. One sample per cycle is sustained while
//   m_axis_tready stays high; the capture machine steps once per sample.
// Reset
//   rst_n clears the pipeline valids and the capture machine (initialize
//   state, counters and sync history zero) and loads the default timing.
// Stalls
//   When m_axis_tready is low the result holds and the input register still
//   accepts one more sample; s_axis_tready then drops until the result moves.
module vga_timing_capture
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [2:0] tick_phase, [3] hsync_level, [4] vsync_level,
    // [12:5] red_in, [20:13] green_in, [28:21] blue_in, [31:29] unused
    input  logic [vtc_pkg::IN_W-1:0]      s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [7:0] red_out, [15:8] green_out, [23:16] blue_out
    output logic [vtc_pkg::OUT_W-1:0]     m_axis_tdata,
    // [0] pixel_valid, [1] line_start, [2] frame_start
    output logic [vtc_pkg::USER_W-1:0]    m_axis_tuser,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [vtc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [vtc_pkg::CFG_DAT_W-1:0] cfg_data
);
    import vtc_pkg::*;

    timing_cfg_t cfg_reg;
    sample_t     in_data_reg;
    logic        in_valid_reg;
    logic        out_valid_reg;
    logic [OUT_W-1:0]  out_data_reg;
    logic [USER_W-1:0] out_user_reg;

    logic    advance;
    result_t result;
    sample_t in_sample;

    // unpack the lowest-first tdata layout
    assign in_sample.tick_phase  = s_axis_tdata[2:0];
    assign in_sample.hsync_level = s_axis_tdata[3];
    assign in_sample.vsync_level = s_axis_tdata[4];
    assign in_sample.red_in      = s_axis_tdata[12:5];
    assign in_sample.green_in    = s_axis_tdata[20:13];
    assign in_sample.blue_in     = s_axis_tdata[28:21];

    // input register moves on when the output register is free or draining
    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign cfg_ready     = 1'b1;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.h_back_porch <= H_BACK_PORCH_RST;
            cfg_reg.h_visible    <= H_VISIBLE_RST;
            cfg_reg.v_visible    <= V_VISIBLE_RST;
            cfg_reg.v_back_porch <= V_BACK_PORCH_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_H_BACK_PORCH: cfg_reg.h_back_porch <= cfg_data[7:0];
                REG_H_VISIBLE:    cfg_reg.h_visible    <= cfg_data[10:0];
                REG_V_VISIBLE:    cfg_reg.v_visible    <= cfg_data[8:0];
                REG_V_BACK_PORCH: cfg_reg.v_back_porch <= cfg_data[5:0];
                default:          cfg_reg <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_data_reg <= in_sample;
        end
        if (advance)
        begin
            out_data_reg <= {result.blue_out, result.green_out, result.red_out};
            out_user_reg <= {result.frame_start, result.line_start, result.pixel_valid};
        end
    end

    vtc_core u_core
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .sample (in_data_reg),
        .cfg    (cfg_reg),
        .result (result)
    );

endmodule

// File: rtl/vtc_checker.sv
// Port-level checks for vga_timing_capture, bound to the top level.
`include "vga_timing_capture_macros.svh"

module vtc_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [vtc_pkg::OUT_W-1:0]     m_axis_tdata,
    input logic [vtc_pkg::USER_W-1:0]    m_axis_tuser
);
    import vtc_pkg::*;

    // a stalled result holds its payload
    `VTC_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready,
        m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

    // pixel, line start and frame start come from different capture states
    `VTC_ASSERT_ALWAYS(a_flags_exclusive, !m_axis_tvalid || $onehot0(m_axis_tuser))

    // color is zero unless a pixel was captured
    `VTC_ASSERT_ALWAYS(a_color_zero, !m_axis_tvalid || m_axis_tuser[0] || (m_axis_tdata == '0))

endmodule

bind vga_timing_capture vtc_checker u_vtc_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// File: tb/tb_vga_timing_capture.sv
// Self-checking testbench for the video timing capture block.
`timescale 1ns / 100ps

module tb_vga_timing_capture;
    import vtc_pkg::*;

    localparam int STALL_LIMIT   = 4000;  // cycles with no transfer before the run is abandoned
    localparam int HOLD_CYCLES   = 300;   // long receiver hold-off to fill the block
    localparam int DRAIN_CYCLES  = 8;     // settle time after the last result
    localparam int RANDOM_ITEMS  = 200;
    localparam int RANDOM_PHASES = 5;
    localparam int MAX_REPORTS   = 10;
    localparam logic [2:0] DOT_PHASE = 3'(CLOCK_DIVIDE - 1);

    logic clk = 1'b0;
    logic rst_n;

    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [IN_W-1:0]      s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [OUT_W-1:0]     m_axis_tdata;
    logic [USER_W-1:0]    m_axis_tuser;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_DAT_W-1:0] cfg_data;

    // Predicted capture machine, advanced once per accepted sample.
    timing_cfg_t    cur_timing;
    capture_state_t cap_state;
    logic [10:0]    dot_cnt;
    logic [8:0]     line_cnt;
    logic [5:0]     vblank_cnt;
    logic           prev_hs;
    logic           prev_vs;

    result_t expected_results[$];

    int  mismatch_count = 0;
    int  items_sent     = 0;
    int  quiet_cycles   = 0;
    int  sink_hold_left = 0;
    bit  src_idle_on    = 1'b0;
    bit  sink_stall_on  = 1'b0;
    int  dot_pct        = 60;   // share of samples that land on the dot phase
    int  noise_pct      = 0;    // share of samples with scrambled sync and phase

    vga_timing_capture DUT
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #4 clk = ~clk;

    //------------------------------------------------------------------
    // Capture machine prediction
    //------------------------------------------------------------------

    // Rising edges are judged against the previous sample, which is
    // updated on every sample, dot tick or not.
    function automatic result_t capture_predict(input sample_t s);
        result_t r;
        logic    h_rise;
        logic    v_rise;
        r      = '0;
        h_rise = !prev_hs && s.hsync_level;
        v_rise = !prev_vs && s.vsync_level;
        if (int'(s.tick_phase) == CLOCK_DIVIDE - 1)
        begin
            dot_cnt = dot_cnt + 11'd1;
            case (cap_state)
                ST_INIT, ST_WAIT_H:
                begin
                    if (h_rise)
                    begin
                        cap_state = ST_HBP;
                        dot_cnt   = '0;
                    end
                end
                ST_HBP:
                begin
                    if (dot_cnt >= 11'(cur_timing.h_back_porch))
                    begin
                        cap_state    = ST_DISPLAY;
                        dot_cnt      = '0;
                        line_cnt     = line_cnt + 9'd1;
                        r.line_start = 1'b1;
                    end
                end
                ST_DISPLAY:
                begin
                    // the tick that reaches the count still captures
                    r.pixel_valid = 1'b1;
                    r.red_out     = s.red_in & COLOR_MASK;
                    r.green_out   = s.green_in & COLOR_MASK;
                    r.blue_out    = s.blue_in & COLOR_MASK;
                    if (dot_cnt >= cur_timing.h_visible)
                    begin
                        if (line_cnt < cur_timing.v_visible)
                        begin
                            cap_state = ST_WAIT_H;
                            dot_cnt   = '0;
                        end
                        else
                            cap_state = ST_WAIT_V;
                    end
                end
                ST_WAIT_V:
                begin
                    if (v_rise)
                    begin
                        cap_state  = ST_VBP;
                        dot_cnt    = '0;
                        vblank_cnt = '0;
                    end
                end
                ST_VBP:
                begin
                    if (h_rise)
                    begin
                        vblank_cnt = vblank_cnt + 6'd1;
                        if (vblank_cnt >= cur_timing.v_back_porch)
                        begin
                            // all ones, so the next dot tick opens the back porch at zero
                            r.frame_start = 1'b1;
                            cap_state     = ST_HBP;
                            dot_cnt       = '1;
                            line_cnt      = '0;
                        end
                    end
                end
                default: cap_state = ST_INIT;
            endcase
        end
        prev_hs = s.hsync_level;
        prev_vs = s.vsync_level;
        return r;
    endfunction

    function automatic void timing_write(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DAT_W-1:0] word);
        case (idx)
            REG_H_BACK_PORCH: cur_timing.h_back_porch = word[7:0];
            REG_H_VISIBLE:    cur_timing.h_visible    = word[10:0];
            REG_V_VISIBLE:    cur_timing.v_visible    = word[8:0];
            REG_V_BACK_PORCH: cur_timing.v_back_porch = word[5:0];
            default: ;
        endcase
    endfunction

    //------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off when requested
    //------------------------------------------------------------------
    initial m_axis_tready = 1'b0;

    always @(negedge clk)
    begin
        if (sink_hold_left > 0)
        begin
            sink_hold_left = sink_hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else if (sink_stall_on)
            m_axis_tready <= ($urandom_range(0, 99) >= 25);
        else
            m_axis_tready <= 1'b1;
    end

    //------------------------------------------------------------------
    // Result check: every output transfer against the oldest prediction
    //------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        result_t seen;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            seen.red_out     = m_axis_tdata[7:0];
            seen.green_out   = m_axis_tdata[15:8];
            seen.blue_out    = m_axis_tdata[23:16];
            seen.pixel_valid = m_axis_tuser[0];
            seen.line_start  = m_axis_tuser[1];
            seen.frame_start = m_axis_tuser[2];
            if (expected_results.size() == 0)
            begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display("%0t: result with nothing expected: tdata=%h tuser=%b",
                             $time, m_axis_tdata, m_axis_tuser);
            end
            else
            begin
                want = expected_results.pop_front();
                if (seen !== want)
                begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS)
                        $display({"%0t: mismatch pv/ls/fs exp %b%b%b got %b%b%b, ",
                                  "rgb exp %h_%h_%h got %h_%h_%h"}, $time,
                                 want.pixel_valid, want.line_start, want.frame_start,
                                 seen.pixel_valid, seen.line_start, seen.frame_start,
                                 want.red_out, want.green_out, want.blue_out,
                                 seen.red_out, seen.green_out, seen.blue_out);
                end
            end
        end
    end

    //------------------------------------------------------------------
    // Watchdog: too long without any transfer ends the run
    //------------------------------------------------------------------
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL vga_timing_capture");
            $finish;
        end
    end

    //------------------------------------------------------------------
    // Stimulus helpers
    //------------------------------------------------------------------

    // Called and returns at a falling edge; valid stays high between
    // back-to-back samples.
    task automatic send_sample(input sample_t s);
        while (src_idle_on && $urandom_range(0, 99) < 25)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        // [2:0] phase, [3] hsync, [4] vsync, [12:5] red, [20:13] green, [28:21] blue
        s_axis_tdata  <= {3'b000, s.blue_in, s.green_in, s.red_in,
                          s.vsync_level, s.hsync_level, s.tick_phase};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        expected_results.push_back(capture_predict(s));
        items_sent++;
        @(negedge clk);
    endtask

    // One sample of the video pins; on_dot forces the dot phase unless noise scrambles it.
    task automatic video_sample(input logic hs, input logic vs, input bit on_dot,
                                output bit was_dot);
        sample_t s;
        s.hsync_level = hs;
        s.vsync_level = vs;
        if (on_dot || $urandom_range(0, 99) < dot_pct)
            s.tick_phase = DOT_PHASE;
        else
            s.tick_phase = 3'($urandom_range(0, CLOCK_DIVIDE - 2));
        if ($urandom_range(0, 99) < noise_pct)
        begin
            s.hsync_level = 1'($urandom);
            s.vsync_level = 1'($urandom);
            s.tick_phase  = 3'($urandom);
        end
        s.red_in   = 8'($urandom);
        s.green_in = 8'($urandom);
        s.blue_in  = 8'($urandom);
        was_dot    = (s.tick_phase == DOT_PHASE);
        send_sample(s);
    endtask

    // hsync low, optional vsync edge, hsync rise, then dots of high hsync.
    task automatic video_line(input logic vs_level, input bit vs_edge, input int dots);
        int n_dots;
        bit d;
        n_dots = 0;
        repeat ($urandom_range(1, 3))
            video_sample(1'b0, vs_edge ? 1'b0 : vs_level, 1'b0, d);
        if (vs_edge)
            video_sample(1'b0, 1'b1, 1'b1, d);
        // a rise off the dot phase is missed; let noise break a few lines
        video_sample(1'b1, vs_level, ($urandom_range(0, 99) >= noise_pct), d);
        while (n_dots < dots)
        begin
            video_sample(1'b1, vs_level, 1'b0, d);
            n_dots += d;
        end
    endtask

    // Visible lines, then vsync and the vertical back porch lines; the last
    // porch line runs full length since the new frame starts inside it.
    task automatic video_frame();
        int full;
        int porch_lines;
        full = int'(cur_timing.h_back_porch) + int'(cur_timing.h_visible) + 3;
        porch_lines = (cur_timing.v_back_porch == 0) ? 1 : int'(cur_timing.v_back_porch);
        repeat (int'(cur_timing.v_visible))
            video_line(1'b0, 1'b0, full + $urandom_range(0, 2));
        for (int i = 0; i < porch_lines; i++)
            video_line(1'b1, (i == 0), (i == porch_lines - 1) ? full : $urandom_range(1, 3));
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES)
            @(negedge clk);
    endtask

    // Leaves cfg_valid high; load_timing lowers it after the last write.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] word);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= word;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        timing_write(idx, word);
        @(negedge clk);
    endtask

    task automatic load_timing(input logic [CFG_DAT_W-1:0] hbp, input logic [CFG_DAT_W-1:0] hvis,
                               input logic [CFG_DAT_W-1:0] vvis, input logic [CFG_DAT_W-1:0] vbp);
        drain_results();
        write_reg(REG_H_BACK_PORCH, hbp);
        write_reg(REG_H_VISIBLE, hvis);
        write_reg(REG_V_VISIBLE, vvis);
        write_reg(REG_V_BACK_PORCH, vbp);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Flags change on the rising edge so the falling-edge processes see them cleanly.
    task automatic set_idling(input bit on);
        @(posedge clk);
        src_idle_on   = on;
        sink_stall_on = on;
        @(negedge clk);
    endtask

    //------------------------------------------------------------------
    // Tests
    //------------------------------------------------------------------

    // Reset timing: every phase, both sync levels, color extremes, an hsync
    // rise off the dot phase (missed) and one on it.
    task automatic test_directed_samples();
        for (int p = 0; p < CLOCK_DIVIDE; p++)
            send_sample({3'(p), 1'b1, 1'b1, 8'hFF, 8'hFF, 8'hFF});
        send_sample({DOT_PHASE, 1'b0, 1'b0, 8'h00, 8'h00, 8'h00});
        send_sample({3'd3, 1'b1, 1'b0, 8'hFF, 8'h00, 8'hFF});
        send_sample({DOT_PHASE, 1'b1, 1'b1, 8'h00, 8'hFF, 8'h00});
        send_sample({DOT_PHASE, 1'b0, 1'b0, 8'hA5, 8'h5A, 8'hC3});
        send_sample({DOT_PHASE, 1'b1, 1'b0, 8'h3C, 8'hC3, 8'h5A});
        for (int i = 0; i < 8; i++)
            send_sample({(i[0] ? DOT_PHASE : 3'(i)), 1'(i[1]), 1'(i[2]),
                         8'($urandom), 8'($urandom), 8'($urandom)});
    endtask

    // Zero registers: back porch ends at once, one line of one pixel per frame,
    // vertical porch ends on the first hsync rise.
    task automatic test_zero_registers();
        load_timing('0, '0, '0, '0);
        dot_pct   = 80;
        noise_pct = 0;
        repeat (6)
            video_frame();
    endtask

    // Long line and porch, no idling on either side.
    task automatic test_wide_line();
        load_timing(11'd60, 11'd40, 11'd1, 11'd2);
        set_idling(1'b0);
        dot_pct = 100;
        video_frame();
    endtask

    // Many short lines in one frame.
    task automatic test_tall_frame();
        load_timing(11'd1, 11'd1, 11'd16, 11'd1);
        set_idling(1'b1);
        dot_pct = 100;
        video_frame();
    endtask

    // Receiver holds off while samples keep coming, so the input must stall.
    task automatic test_output_hold_off();
        dot_pct = 70;
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        sink_hold_left = HOLD_CYCLES;
        @(negedge clk);
        video_line(1'b0, 1'b0, 30);
    endtask

    // Small random timings with junk in the unused data bits, well-formed
    // frames with random colors and some broken syncs.
    task automatic test_random_frames();
        int start;
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            load_timing({3'($urandom), 8'($urandom_range(0, 6))},
                        11'($urandom_range(0, 12)),
                        {2'($urandom), 9'($urandom_range(0, 4))},
                        {5'($urandom), 6'($urandom_range(0, 3))});
            dot_pct   = ($urandom_range(0, 3) == 0) ? 100 : 60;
            noise_pct = 5;
            start     = items_sent;
            while (items_sent - start < RANDOM_ITEMS / RANDOM_PHASES)
                video_frame();
        end
    endtask

    //------------------------------------------------------------------
    // Main sequence
    //------------------------------------------------------------------
    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = REG_H_BACK_PORCH;
        cfg_data      = '0;

        cur_timing.h_back_porch = H_BACK_PORCH_RST;
        cur_timing.h_visible    = H_VISIBLE_RST;
        cur_timing.v_visible    = V_VISIBLE_RST;
        cur_timing.v_back_porch = V_BACK_PORCH_RST;
        cap_state  = ST_INIT;
        dot_cnt    = '0;
        line_cnt   = '0;
        vblank_cnt = '0;
        prev_hs    = 1'b0;
        prev_vs    = 1'b0;

        repeat (12)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        set_idling(1'b1);
        test_directed_samples();
        test_zero_registers();
        test_wide_line();
        test_tall_frame();
        test_output_hold_off();
        test_random_frames();

        drain_results();
        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("PASS vga_timing_capture");
        else
            $display("FAIL vga_timing_capture");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/vtc_pkg.sv
rtl/vtc_core.sv
rtl/vga_timing_capture.sv
rtl/vtc_checker.sv
tb/tb_vga_timing_capture.sv
